@@ hdl/pade_pkg.sv @@
// ----------------------------------------------------------------------------
// pade_pkg
// Shared types and constants for the piecewise acceleration displacement
// integrator: word layouts, controller commands and datapath status.
// ----------------------------------------------------------------------------
package pade_pkg;

  localparam int SAMPLE_DEPTH = 64;
  localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int Q_W = 32;
  localparam int PROD_W = 2 * Q_W;
  localparam int ACC_W = 50;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32'h7FFF_FFFF);
  localparam logic signed [Q_W-1:0] Q_MIN = ~Q_MAX;
  localparam logic signed [ACC_W-1:0] ACC_QMAX = {{(ACC_W-Q_W){1'b0}}, Q_MAX};
  localparam logic signed [ACC_W-1:0] ACC_QMIN = ~ACC_QMAX;
  localparam logic signed [PROD_W-1:0] PROD_QMAX = {{(PROD_W-Q_W){1'b0}}, Q_MAX};

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [IDX_W-1:0]      entry_index;
    logic signed [Q_W-1:0] entry_time;
    logic signed [Q_W-1:0] entry_speed;
    logic signed [Q_W-1:0] entry_accel;
    logic signed [Q_W-1:0] fire_time;
    logic                  scan_start;
  } in_word_t;

  typedef struct packed {
    logic signed [Q_W-1:0] displacement;
    logic                  saturated;
  } out_word_t;

  typedef enum logic [1:0] {
    MUL_VDT  = 2'd0,
    MUL_DTDT = 2'd1,
    MUL_ADT  = 2'd2,
    MUL_ASQ  = 2'd3
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE  = 3'd0,
    ACC_ADD16 = 3'd1,
    ACC_SQ    = 3'd2,
    ACC_VUPD  = 3'd3,
    ACC_ADD17 = 3'd4
  } acc_op_t;

  typedef struct packed {
    logic     take;
    logic     start_scan;
    logic     start_point;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     switch_seg;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic in_point;
    logic scan;
    logic split;
    logic out_free;
  } status_t;

  function automatic logic signed [Q_W-1:0] sat_diff(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] d;
    d = {a[Q_W-1], a} - {b[Q_W-1], b};
    if (d[Q_W] != d[Q_W-1]) begin
      return d[Q_W] ? Q_MIN : Q_MAX;
    end
    return d[Q_W-1:0];
  endfunction

  function automatic logic signed [Q_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
    if (x > ACC_QMAX) begin
      return Q_MAX;
    end else if (x < ACC_QMIN) begin
      return Q_MIN;
    end
    return x[Q_W-1:0];
  endfunction

endpackage

@@ hdl/pade_ctrl.sv @@
// ----------------------------------------------------------------------------
// pade_ctrl
// Sequencer for the integrator: accepts words, steps the shared multiplier
// through the travel and speed terms, and hands results to the output stage.
// ----------------------------------------------------------------------------
module pade_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pade_pkg::status_t st,
  output pade_pkg::cmd_t    cmd
);
  import pade_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DEC  = 8'b0000_0010,
    ST_M1   = 8'b0000_0100,
    ST_M2   = 8'b0000_1000,
    ST_M3   = 8'b0001_0000,
    ST_M4   = 8'b0010_0000,
    ST_M5   = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   split, split_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      split <= 1'b0;
    end else begin
      state <= state_next;
      split <= split_next;
    end
  end

  always_comb begin
    state_next      = state;
    split_next      = split;
    in_ready        = 1'b0;
    cmd.take        = 1'b0;
    cmd.start_scan  = 1'b0;
    cmd.start_point = 1'b0;
    cmd.mul_sel     = MUL_VDT;
    cmd.acc_op      = ACC_NONE;
    cmd.switch_seg  = 1'b0;
    cmd.emit        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.in_point) begin
            state_next = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        if (st.scan) begin
          cmd.start_scan = 1'b1;
          state_next     = ST_OUT;
        end else begin
          cmd.start_point = 1'b1;
          split_next      = st.split;
          state_next      = ST_M1;
        end
      end
      ST_M1: begin
        cmd.mul_sel = MUL_VDT;
        state_next  = ST_M2;
      end
      ST_M2: begin
        cmd.mul_sel = MUL_DTDT;
        cmd.acc_op  = ACC_ADD16;
        state_next  = ST_M3;
      end
      ST_M3: begin
        cmd.mul_sel = MUL_ADT;
        cmd.acc_op  = ACC_SQ;
        state_next  = ST_M4;
      end
      ST_M4: begin
        cmd.mul_sel = MUL_ASQ;
        cmd.acc_op  = split ? ACC_NONE : ACC_VUPD;
        state_next  = ST_M5;
      end
      ST_M5: begin
        cmd.acc_op = ACC_ADD17;
        if (split) begin
          cmd.switch_seg = 1'b1;
          split_next     = 1'b0;
          state_next     = ST_M1;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        split_next = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/pade_dpath.sv @@
// ----------------------------------------------------------------------------
// pade_dpath
// Datapath of the integrator: sample table memory, motion state, one shared
// 32x32 signed multiplier with its product register, accumulator and the
// output register.
// ----------------------------------------------------------------------------
module pade_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [pade_pkg::CNT_W-1:0] cfg_data,
  input  pade_pkg::in_word_t         in_data,
  output pade_pkg::out_word_t        out_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  pade_pkg::cmd_t             cmd,
  output pade_pkg::status_t          st
);
  import pade_pkg::*;

  typedef struct packed {
    logic signed [Q_W-1:0] time_q;
    logic signed [Q_W-1:0] speed_q;
    logic signed [Q_W-1:0] accel_q;
  } entry_t;

  entry_t mem [SAMPLE_DEPTH];
  entry_t rd;

  logic [CNT_W-1:0]         sample_count;
  logic signed [Q_W-1:0]    pos;
  logic signed [Q_W-1:0]    speed;
  logic signed [Q_W-1:0]    accel;
  logic [ADDR_W-1:0]        ptr;
  logic signed [Q_W-1:0]    prev_fire;

  in_word_t                 item;
  logic signed [ACC_W-1:0]  acc;
  logic signed [Q_W-1:0]    dt;
  logic signed [Q_W-1:0]    sq;
  logic signed [PROD_W-1:0] prod;

  logic [ADDR_W:0]          nxt;
  logic [CNT_W-1:0]         cnt_eff;
  logic                     split;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [Q_W-1:0]    mul_a;
  logic signed [Q_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] p16;
  logic signed [PROD_W-1:0] p17;
  logic signed [ACC_W-1:0]  vsum;
  logic signed [Q_W-1:0]    pos_clamped;
  logic                     pos_ovf;
  logic                     load_ok;

  always_comb begin
    nxt = {1'b0, ptr} + (ADDR_W+1)'(1);
    if (sample_count == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (sample_count > CNT_W'(SAMPLE_DEPTH)) begin
      cnt_eff = CNT_W'(SAMPLE_DEPTH);
    end else begin
      cnt_eff = sample_count;
    end
    split = (CNT_W'(nxt) < cnt_eff) && (rd.time_q <= item.fire_time);
    rd_addr = in_data.scan_start ? '0 : nxt[ADDR_W-1:0];
    load_ok = (CNT_W'(in_data.entry_index) < CNT_W'(SAMPLE_DEPTH));

    case (cmd.mul_sel)
      MUL_VDT: begin
        mul_a = speed;
        mul_b = dt;
      end
      MUL_DTDT: begin
        mul_a = dt;
        mul_b = dt;
      end
      MUL_ADT: begin
        mul_a = accel;
        mul_b = dt;
      end
      MUL_ASQ: begin
        mul_a = accel;
        mul_b = sq;
      end
      default: begin
        mul_a = speed;
        mul_b = dt;
      end
    endcase

    p16  = prod >>> 16;
    p17  = prod >>> 17;
    vsum = {{(ACC_W-Q_W){speed[Q_W-1]}}, speed} + p16[ACC_W-1:0];

    pos_ovf     = (acc > ACC_QMAX) || (acc < ACC_QMIN);
    pos_clamped = sat_acc(acc);

    st.in_point = (in_data.req_type == REQ_POINT);
    st.scan     = item.scan_start;
    st.split    = split;
    st.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd <= mem[rd_addr];
      if (in_data.req_type == REQ_LOAD && load_ok) begin
        mem[in_data.entry_index[ADDR_W-1:0]] <= '{time_q:  in_data.entry_time,
                                                   speed_q: in_data.entry_speed,
                                                   accel_q: in_data.entry_accel};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_data;
    end
    prod <= mul_a * mul_b;
    if (cmd.start_scan) begin
      acc <= '0;
    end else if (cmd.start_point) begin
      acc <= {{(ACC_W-Q_W){pos[Q_W-1]}}, pos};
      dt  <= split ? sat_diff(rd.time_q, prev_fire) : sat_diff(item.fire_time, prev_fire);
    end else if (cmd.switch_seg) begin
      dt <= sat_diff(item.fire_time, rd.time_q);
    end
    case (cmd.acc_op)
      ACC_ADD16: begin
        acc <= acc + p16[ACC_W-1:0];
      end
      ACC_ADD17: begin
        acc <= acc + p17[ACC_W-1:0];
      end
      ACC_SQ: begin
        sq <= (p16 > PROD_QMAX) ? Q_MAX : p16[Q_W-1:0];
      end
      default: begin
      end
    endcase
    if (cmd.emit) begin
      out_data <= '{displacement: pos_clamped, saturated: pos_ovf};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= CNT_W'(1);
      pos          <= '0;
      speed        <= '0;
      accel        <= '0;
      ptr          <= '0;
      prev_fire    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        sample_count <= cfg_data;
      end
      if (cmd.start_scan) begin
        ptr   <= '0;
        speed <= rd.speed_q;
        accel <= rd.accel_q;
      end else if (cmd.start_point && split) begin
        ptr <= nxt[ADDR_W-1:0];
      end else if (cmd.switch_seg) begin
        speed <= rd.speed_q;
        accel <= rd.accel_q;
      end else if (cmd.acc_op == ACC_VUPD) begin
        speed <= sat_acc(vsum);
      end
      if (cmd.emit) begin
        pos       <= pos_clamped;
        prev_fire <= item.fire_time;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/piecewise_accel_displacement_integrator.sv @@
// ----------------------------------------------------------------------------
// piecewise_accel_displacement_integrator
// Dead-reckoning integrator over a table of constant-acceleration motion
// samples, with a sequencer and a multiplier datapath.
//
//   Channel   Signals                        Word
//   input     in_valid, in_ready, in_data    load or point request
//   output    out_valid, out_ready, out_data displacement and clamp flag
//   config    cfg_valid, cfg_ready, cfg_data sample count
//
// A load word is taken in the idle state. A scan-start point passes the
// decode and output states; a point inside one sample runs the multiply
// states M1 to M5 once, one that crosses into the next sample runs them
// once per segment, and the shared 32x32 multiplier forms four products
// per segment. Reset is synchronous and needs no clearing pass. A stalled
// output holds one result while the next word is accepted and worked on.
// ----------------------------------------------------------------------------
module piecewise_accel_displacement_integrator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pade_pkg::CNT_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pade_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pade_pkg::out_word_t        out_data
);
  import pade_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  pade_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pade_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

@@ dv/piecewise_accel_displacement_integrator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise acceleration displacement integrator testbench
// Loads motion sample tables, runs scans of point words across them and
// checks every displacement word against an in-bench dead-reckoning model
// or a fixed expected word. A short directed table covers range extremes,
// splits and saturation. Randomized phases at several sample counts
// follow, with bursty stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module piecewise_accel_displacement_integrator_test;
  import pade_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 216;
  localparam int SETTLE_CYCLES = 24;
  localparam longint QTOP = 64'sd2147483647;
  localparam longint QBOT = -64'sd2147483648;
  localparam out_word_t NO_TRAVEL = '0;
  localparam out_word_t PINNED_HI = {Q_MAX, 1'b1};
  localparam out_word_t PINNED_LO = {Q_MIN, 1'b1};

  typedef enum logic {ROW_WORD, ROW_COUNT} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CNT_W-1:0] count;
    in_word_t         word;
    bit               fixed;
    out_word_t        want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;

  longint tbl_time[SAMPLE_DEPTH];
  longint tbl_speed[SAMPLE_DEPTH];
  longint tbl_accel[SAMPLE_DEPTH];
  longint dr_pos = 0;
  longint dr_speed = 0;
  longint dr_accel = 0;
  longint dr_prev = 0;
  int dr_ptr = 0;
  logic [CNT_W-1:0] dr_count = 1;

  longint plan_t[SAMPLE_DEPTH];
  out_word_t due_disp[$];
  row_t steps[$];

  int faults = 0;
  int words = 0;
  int loads = 0;
  int points = 0;
  int results = 0;
  int settings = 0;
  int cycles = 0;
  bit calm = 1'b0;

  piecewise_accel_displacement_integrator dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_q(input longint x);
    if (x > QTOP) begin
      return QTOP;
    end else if (x < QBOT) begin
      return QBOT;
    end
    return x;
  endfunction

  function automatic longint glide(input longint v, input longint a, input longint dt);
    longint sq;
    sq = (dt * dt) >>> 16;
    if (sq > QTOP) begin
      sq = QTOP;
    end
    return ((v * dt) >>> 16) + ((a * sq) >>> 17);
  endfunction

  function automatic bit dead_reckon(input in_word_t w, output out_word_t r);
    longint fire, pos, dt, ts;
    int lim, nxt;
    r = '0;
    if (w.req_type == REQ_LOAD) begin
      tbl_time[w.entry_index] = $signed(w.entry_time);
      tbl_speed[w.entry_index] = $signed(w.entry_speed);
      tbl_accel[w.entry_index] = $signed(w.entry_accel);
      return 1'b0;
    end
    fire = $signed(w.fire_time);
    if (w.scan_start) begin
      dr_pos = 0;
      dr_ptr = 0;
      dr_speed = tbl_speed[0];
      dr_accel = tbl_accel[0];
      dr_prev = fire;
      return 1'b1;
    end
    lim = int'(dr_count);
    if (lim < 1) begin
      lim = 1;
    end
    if (lim > SAMPLE_DEPTH) begin
      lim = SAMPLE_DEPTH;
    end
    pos = dr_pos;
    nxt = dr_ptr + 1;
    if (nxt < lim && tbl_time[nxt] <= fire) begin
      ts = tbl_time[nxt];
      dr_ptr = nxt;
      pos += glide(dr_speed, dr_accel, clamp_q(ts - dr_prev));
      dr_speed = tbl_speed[nxt];
      dr_accel = tbl_accel[nxt];
      dt = clamp_q(fire - ts);
    end else begin
      dt = clamp_q(fire - dr_prev);
    end
    pos += glide(dr_speed, dr_accel, dt);
    dr_speed = clamp_q(dr_speed + ((dr_accel * dt) >>> 16));
    r.saturated = (pos > QTOP || pos < QBOT);
    pos = clamp_q(pos);
    dr_pos = pos;
    dr_prev = fire;
    r.displacement = pos[Q_W-1:0];
    return 1'b1;
  endfunction

  function automatic int spread(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic in_word_t ld(input logic [IDX_W-1:0] idx, input logic signed [Q_W-1:0] t,
                                  input logic signed [Q_W-1:0] s,
                                  input logic signed [Q_W-1:0] a);
    in_word_t w;
    w.req_type = REQ_LOAD;
    w.entry_index = idx;
    w.entry_time = t;
    w.entry_speed = s;
    w.entry_accel = a;
    w.fire_time = $urandom;
    w.scan_start = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic in_word_t pt(input logic signed [Q_W-1:0] fire, input logic scan);
    in_word_t w;
    w.req_type = REQ_POINT;
    w.entry_index = IDX_W'($urandom_range(0, SAMPLE_DEPTH - 1));
    w.entry_time = $urandom;
    w.entry_speed = $urandom;
    w.entry_accel = $urandom;
    w.fire_time = fire;
    w.scan_start = scan;
    return w;
  endfunction

  task automatic add_row(input row_t r);
    steps.insert(steps.size(), r);
  endtask

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= 10) begin
      $display("%t: %s", $realtime, msg);
    end
  endtask

  task automatic push_word(input in_word_t w, input bit fixed, input out_word_t want);
    out_word_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (dead_reckon(w, r)) begin
      due_disp.insert(due_disp.size(), fixed ? want : r);
    end
    words++;
    if (w.req_type == REQ_LOAD) begin
      loads++;
    end else begin
      points++;
    end
    @(negedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (due_disp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    dr_count = v;
    settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_table(input int eff);
    longint t;
    bit wild;
    logic signed [Q_W-1:0] s, a;
    wild = ($urandom_range(0, 5) == 0);
    t = spread('h10_0000);
    for (int i = 0; i < eff; i++) begin
      plan_t[i] = t;
      if (wild) begin
        s = $urandom;
        a = $urandom;
      end else begin
        s = spread('h64_0000);
        a = spread('h0A_0000);
      end
      push_word(ld(IDX_W'(i), Q_W'(t), s, a), 1'b0, NO_TRAVEL);
      t += $urandom_range('h200, 'h2_8000);
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] cnt, input int budget);
    int eff, stop, pick, len, idx;
    longint fire, t;
    write_count(cnt);
    eff = (cnt < 1) ? 1 : (cnt > SAMPLE_DEPTH) ? SAMPLE_DEPTH : int'(cnt);
    stop = words + budget;
    fill_table(eff);
    while (words < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(2, 24);
        fire = plan_t[0] - $urandom_range(0, 'h4000);
        push_word(pt(Q_W'(fire), 1'b1), 1'b0, NO_TRAVEL);
        repeat (len) begin
          fire += $urandom_range(0, 'h2_0000);
          if ($urandom_range(0, 29) == 0) begin
            fire -= $urandom_range(0, 'h2_0000);
          end
          push_word(pt(Q_W'(fire), 1'b0), 1'b0, NO_TRAVEL);
        end
      end else if (pick < 84) begin
        fill_table(eff);
      end else if (pick < 92) begin
        idx = $urandom_range(0, SAMPLE_DEPTH - 1);
        if ($urandom_range(0, 1) == 0) begin
          t = plan_t[idx] + spread('h800);
          push_word(ld(IDX_W'(idx), Q_W'(t), spread('h64_0000), spread('h0A_0000)),
                    1'b0, NO_TRAVEL);
        end else begin
          t = $signed($urandom);
          push_word(ld(IDX_W'(idx), Q_W'(t), $urandom, $urandom), 1'b0, NO_TRAVEL);
        end
        plan_t[idx] = t;
      end else begin
        push_word(pt($urandom, 1'($urandom_range(0, 1))), 1'b0, NO_TRAVEL);
      end
    end
  endtask

  initial begin : receiver
    int stall;
    bit squeezed;
    stall = 0;
    squeezed = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeezed && points >= 300) begin
        squeezed = 1'b1;
        stall = 600;
      end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : disp_check
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_disp.size() == 0) begin
        log_fault($sformatf("unexpected word: displacement %h saturated %b",
                            out_data.displacement, out_data.saturated));
      end else begin
        want = due_disp.pop_front();
        results++;
        if (out_data.displacement !== want.displacement) begin
          log_fault($sformatf("result %0d: displacement %h, expected %h", results,
                              out_data.displacement, want.displacement));
        end
        if (out_data.saturated !== want.saturated) begin
          log_fault($sformatf("result %0d: saturated %b, expected %b", results,
                              out_data.saturated, want.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", due_disp.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] counts[8];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;

    add_row('{ROW_WORD, '0, pt(32'h7FFF_FFFF, 1'b0), 1'b1, NO_TRAVEL});
    add_row('{ROW_WORD, '0, ld(IDX_W'(0), 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h8000_0000, 1'b1), 1'b1, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h7FFF_FFFF, 1'b0), 1'b1, PINNED_HI});
    add_row('{ROW_WORD, '0, pt(32'h8000_0000, 1'b0), 1'b1, PINNED_LO});
    add_row('{ROW_WORD, '0, ld(IDX_W'(0), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
              1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0000_0000, 1'b1), 1'b1, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h7FFF_FFFF, 1'b0), 1'b1, PINNED_LO});
    add_row('{ROW_COUNT, 7'd2, '0, 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, ld(IDX_W'(1), 32'h0001_0000, 32'h0002_0000, 0), 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, ld(IDX_W'(0), 0, 32'h0001_0000, 32'h0001_0000), 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0000_0000, 1'b1), 1'b1, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0000_8000, 1'b0), 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0001_0000, 1'b0), 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0001_8000, 1'b0), 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0001_8000, 1'b0), 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0001_0000, 1'b0), 1'b0, NO_TRAVEL});
    add_row('{ROW_COUNT, 7'd0, '0, 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0002_0000, 1'b1), 1'b1, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0003_0000, 1'b0), 1'b0, NO_TRAVEL});
    add_row('{ROW_COUNT, 7'd127, '0, 1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, ld(IDX_W'(63), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
              1'b0, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h0002_0000, 1'b1), 1'b1, NO_TRAVEL});
    add_row('{ROW_WORD, '0, pt(32'h7FFF_FFFF, 1'b0), 1'b0, NO_TRAVEL});

    counts = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd2, CNT_W'($urandom_range(3, 63)), 7'd33,
               CNT_W'($urandom_range(0, 127))};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_COUNT) begin
        write_count(steps[i].count);
      end else begin
        push_word(steps[i].word, steps[i].fixed, steps[i].want);
      end
    end

    foreach (counts[p]) begin
      if (p == 7) begin
        calm = 1'b1;
      end
      run_phase(counts[p], PHASE_WORDS);
    end

    in_valid <= 1'b0;
    while (due_disp.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d words (%0d loads, %0d points) across %0d sample-count settings.",
             words, loads, points, settings);
    $display("Checked %0d displacement words in %0d cycles; %0d faults.", results, cycles,
             faults);
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pade_pkg.sv
hdl/pade_ctrl.sv
hdl/pade_dpath.sv
hdl/piecewise_accel_displacement_integrator.sv
dv/piecewise_accel_displacement_integrator_test.sv
